/* rtl/core/route_from_predecessor_table_unit_macros.svh */
// Assertion macros shared by the route table RTL.
`ifndef ROUTE_FROM_PREDECESSOR_TABLE_UNIT_MACROS_SVH
`define ROUTE_FROM_PREDECESSOR_TABLE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check a property on every rising edge outside of reset.
`define RFP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that a condition never holds.
`define RFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  `RFP_ASSERT(lbl, clk, rst_n, !(cond), msg)
`else
`define RFP_ASSERT(lbl, clk, rst_n, prop, msg)
`define RFP_ASSERT_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* rtl/core/rfp_pkg.sv */
`timescale 1ns / 1ps
package rfp_pkg;

  localparam int NodesDef     = 64;
  localparam int CostWidthDef = 32;
  localparam int EntryWidth   = 32;
  localparam int OutCostWidth = 32;
  localparam int ModeWidth    = 3;

  typedef enum logic [ModeWidth-1:0] {
    MODE_WR_PRED = 3'd0,
    MODE_WR_DIST = 3'd1,
    MODE_WR_DUR  = 3'd2,
    MODE_COST    = 3'd3,
    MODE_ROUTE   = 3'd4
  } mode_e;

  // Table port command
  typedef struct packed {
    logic pred_we;
    logic dist_we;
    logic dur_we;
    logic pred_re;
    logic cost_re;
  } tbl_cmd_t;

endpackage

/* rtl/core/rfp_tables.sv */
`timescale 1ns / 1ps
module rfp_tables #(
  parameter int Nodes       = rfp_pkg::NodesDef,
  parameter int CostWidth   = rfp_pkg::CostWidthDef,
  localparam int NodeW      = $clog2(Nodes + 1),
  localparam int Depth      = Nodes * Nodes,
  localparam int AddrW      = $clog2(Depth)
) (
  input  logic                  clk_i,
  input  rfp_pkg::tbl_cmd_t     cmd_i,
  input  logic [AddrW-1:0]      addr_i,
  input  logic [NodeW-1:0]      pred_wdata_i,
  input  logic [CostWidth-1:0]  cost_wdata_i,
  output logic [NodeW-1:0]      pred_rdata_o,
  output logic [CostWidth-1:0]  dist_rdata_o,
  output logic [CostWidth-1:0]  dur_rdata_o
);

  logic [NodeW-1:0]     pred_mem [Depth];
  logic [CostWidth-1:0] dist_mem [Depth];
  logic [CostWidth-1:0] dur_mem  [Depth];

  logic [NodeW-1:0]     pred_rdata_q;
  logic [CostWidth-1:0] dist_rdata_q;
  logic [CostWidth-1:0] dur_rdata_q;

  // Read data holds until the next read of that table.
  always_ff @(posedge clk_i) begin
    if (cmd_i.pred_we) begin
      pred_mem[addr_i] <= pred_wdata_i;
    end
    if (cmd_i.pred_re) begin
      pred_rdata_q <= pred_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dist_we) begin
      dist_mem[addr_i] <= cost_wdata_i;
    end
    if (cmd_i.cost_re) begin
      dist_rdata_q <= dist_mem[addr_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.dur_we) begin
      dur_mem[addr_i] <= cost_wdata_i;
    end
    if (cmd_i.cost_re) begin
      dur_rdata_q <= dur_mem[addr_i];
    end
  end

  assign pred_rdata_o = pred_rdata_q;
  assign dist_rdata_o = dist_rdata_q;
  assign dur_rdata_o  = dur_rdata_q;

endmodule

/* rtl/core/rfp_stack.sv */
`timescale 1ns / 1ps
module rfp_stack #(
  parameter int Nodes  = rfp_pkg::NodesDef,
  localparam int NodeW = $clog2(Nodes + 1),
  localparam int AddrW = $clog2(Nodes * Nodes),
  localparam int IdxW  = $clog2(Nodes),
  localparam int LegW  = 2 * NodeW + AddrW
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [IdxW-1:0]  idx_i,
  input  logic [LegW-1:0]  wdata_i,
  output logic [LegW-1:0]  rdata_o
);

  // One entry per leg: from node, to node, cost table address
  logic [LegW-1:0] leg_mem [Nodes];
  logic [LegW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      leg_mem[idx_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= leg_mem[idx_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/route_from_predecessor_table_unit.sv */
`timescale 1ns / 1ps
// Route table unit: holds Nodes x Nodes tables of predecessor, leg distance (mm) and leg
// duration (ms) in single-port synchronous memories, and answers cost and route queries.
// Write beats are taken one per cycle while idle. A cost query reads both cost tables and
// presents its single result from the output registers; the next beat can be taken once
// that result is emitted. A route query walks the predecessor memory at one hop per cycle
// (its read data forms the next read address), pushing each leg onto a leg stack memory,
// then replays the legs from the stack, after the S_LEG_FIRST and S_LEG_LOAD steps fill
// the read pipe, at one result per cycle while the output does not stall, and finishes
// with the flag step. The input stalls while a query is in progress; the result
// register lets the last result wait while the next beat is taken.
// Memories need no clearing after reset if entries are read only after they have been
// written; the user must ensure this, as the block itself does not enforce it.
`include "route_from_predecessor_table_unit_macros.svh"
module route_from_predecessor_table_unit #(
  parameter int Nodes     = rfp_pkg::NodesDef,
  parameter int CostWidth = rfp_pkg::CostWidthDef,
  localparam int NodeW    = $clog2(Nodes + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [rfp_pkg::ModeWidth-1:0]     mode_i,
  input  logic [NodeW-1:0]                  origin_node_i,
  input  logic [NodeW-1:0]                  dest_node_i,
  input  logic [rfp_pkg::EntryWidth-1:0]    entry_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [NodeW-1:0]                  from_node_o,
  output logic [NodeW-1:0]                  to_node_o,
  output logic [rfp_pkg::OutCostWidth-1:0]  step_distance_mm_o,
  output logic [rfp_pkg::OutCostWidth-1:0]  step_duration_ms_o,
  output logic [rfp_pkg::OutCostWidth-1:0]  total_distance_mm_o,
  output logic [rfp_pkg::OutCostWidth-1:0]  total_duration_ms_o,
  output logic                              last_o
);

  localparam int AddrW = $clog2(Nodes * Nodes);
  localparam int IdxW  = $clog2(Nodes);
  localparam int LegW  = 2 * NodeW + AddrW;
  localparam int OutW  = rfp_pkg::OutCostWidth;

  typedef enum logic [2:0] {
    S_IDLE,
    S_WALK,
    S_LEG_FIRST,
    S_LEG_LOAD,
    S_LEG_EMIT,
    S_FLAG,
    S_COST_EMIT,
    S_BAD_EMIT
  } state_e;

  function automatic logic [AddrW-1:0] cell_addr(input logic [NodeW-1:0] row,
                                                 input logic [NodeW-1:0] col);
    logic [AddrW-1:0] r;
    logic [AddrW-1:0] c;
    r = AddrW'(row);
    c = AddrW'(col);
    return (r - 1'b1) * AddrW'(Nodes) + c - 1'b1;
  endfunction

  function automatic logic [CostWidth-1:0] sat_add(input logic [CostWidth-1:0] a,
                                                   input logic [CostWidth-1:0] b);
    logic [CostWidth:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CostWidth] ? {CostWidth{1'b1}} : s[CostWidth-1:0];
  endfunction

  state_e state_q, state_d;

  logic [IdxW-1:0]      legs_q;
  logic [IdxW-1:0]      leg_idx_q;
  logic                 more_q;
  logic [CostWidth-1:0] dist_sum_q;
  logic [CostWidth-1:0] dur_sum_q;
  logic                 out_valid_q;

  logic [NodeW-1:0]     orig_q;
  logic [NodeW-1:0]     dest_q;
  logic [NodeW-1:0]     cur_q;
  logic [AddrW-1:0]     row_base_q;
  logic [NodeW-1:0]     from_q;
  logic [NodeW-1:0]     to_q;

  logic [NodeW-1:0]     from_node_q;
  logic [NodeW-1:0]     to_node_q;
  logic [OutW-1:0]      step_dist_q;
  logic [OutW-1:0]      step_dur_q;
  logic [OutW-1:0]      tot_dist_q;
  logic [OutW-1:0]      tot_dur_q;
  logic                 last_q;

  rfp_pkg::tbl_cmd_t    tbl_cmd;
  logic [AddrW-1:0]     tbl_addr;
  logic [NodeW-1:0]     pred_wdata;
  logic [CostWidth-1:0] cost_wdata;
  logic [NodeW-1:0]     pred_rd;
  logic [CostWidth-1:0] dist_rd;
  logic [CostWidth-1:0] dur_rd;

  logic                 stk_we;
  logic                 stk_re;
  logic [IdxW-1:0]      stk_idx;
  logic [LegW-1:0]      stk_wdata;
  logic [LegW-1:0]      stk_rd;
  logic [NodeW-1:0]     stk_from;
  logic [NodeW-1:0]     stk_to;
  logic [AddrW-1:0]     stk_addr;

  logic                 in_ok;
  logic                 in_accept;
  logic                 out_free;
  logic                 walk_push;
  logic                 load_leg;
  logic                 emit;
  logic [CostWidth-1:0] dist_next;
  logic [CostWidth-1:0] dur_next;

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;

  assign in_ok = (origin_node_i != '0) && (origin_node_i <= NodeW'(Nodes)) &&
                 (dest_node_i != '0) && (dest_node_i <= NodeW'(Nodes));

  // Out-of-range predecessors become "none".
  assign pred_wdata = ((entry_value_i != '0) &&
                       (entry_value_i <= rfp_pkg::EntryWidth'(Nodes))) ?
                      NodeW'(entry_value_i) : '0;
  assign cost_wdata = CostWidth'(entry_value_i);

  assign stk_from  = stk_rd[LegW-1 -: NodeW];
  assign stk_to    = stk_rd[AddrW +: NodeW];
  assign stk_addr  = stk_rd[AddrW-1:0];
  assign stk_wdata = {pred_rd, cur_q, cell_addr(pred_rd, cur_q)};

  assign dist_next = sat_add(dist_sum_q, dist_rd);
  assign dur_next  = sat_add(dur_sum_q, dur_rd);

  always_comb begin
    state_d   = state_q;
    tbl_cmd   = '0;
    tbl_addr  = cell_addr(origin_node_i, dest_node_i);
    stk_we    = 1'b0;
    stk_re    = 1'b0;
    stk_idx   = legs_q;
    walk_push = 1'b0;
    load_leg  = 1'b0;
    emit      = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (mode_i)
            rfp_pkg::MODE_WR_PRED: tbl_cmd.pred_we = in_ok;
            rfp_pkg::MODE_WR_DIST: tbl_cmd.dist_we = in_ok;
            rfp_pkg::MODE_WR_DUR:  tbl_cmd.dur_we  = in_ok;
            rfp_pkg::MODE_COST: begin
              tbl_cmd.cost_re = in_ok;
              state_d = in_ok ? S_COST_EMIT : S_BAD_EMIT;
            end
            rfp_pkg::MODE_ROUTE: begin
              tbl_cmd.pred_re = in_ok;
              state_d = in_ok ? S_WALK : S_BAD_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // Push the current node's leg and chase its predecessor, until none or full.
        if ((pred_rd != '0) && (legs_q < IdxW'(Nodes - 1))) begin
          walk_push       = 1'b1;
          stk_we          = 1'b1;
          tbl_cmd.pred_re = 1'b1;
          tbl_addr        = row_base_q + AddrW'(pred_rd) - 1'b1;
        end else begin
          state_d = (legs_q == '0) ? S_FLAG : S_LEG_FIRST;
        end
      end
      S_LEG_FIRST: begin
        stk_re  = 1'b1;
        stk_idx = legs_q - 1'b1;
        state_d = S_LEG_LOAD;
      end
      S_LEG_LOAD: begin
        load_leg = 1'b1;
        state_d  = S_LEG_EMIT;
      end
      S_LEG_EMIT: begin
        if (out_free) begin
          emit = 1'b1;
          if (more_q) begin
            load_leg = 1'b1;
          end else begin
            state_d = S_FLAG;
          end
        end
      end
      S_FLAG, S_COST_EMIT, S_BAD_EMIT: begin
        if (out_free) begin
          emit    = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    // Start the cost read of the leg in the stack read register, prefetch the next one.
    if (load_leg) begin
      tbl_cmd.cost_re = 1'b1;
      tbl_addr        = stk_addr;
      if (leg_idx_q != '0) begin
        stk_re  = 1'b1;
        stk_idx = leg_idx_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      legs_q      <= '0;
      leg_idx_q   <= '0;
      more_q      <= 1'b0;
      dist_sum_q  <= '0;
      dur_sum_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept && (mode_i == rfp_pkg::MODE_ROUTE)) begin
        legs_q     <= '0;
        dist_sum_q <= '0;
        dur_sum_q  <= '0;
      end
      if (walk_push) begin
        legs_q <= legs_q + 1'b1;
      end
      if (state_q == S_LEG_FIRST) begin
        leg_idx_q <= legs_q - 1'b1;
      end
      if (load_leg) begin
        more_q <= (leg_idx_q != '0);
        if (leg_idx_q != '0) begin
          leg_idx_q <= leg_idx_q - 1'b1;
        end
      end
      if (emit && (state_q == S_LEG_EMIT)) begin
        dist_sum_q <= dist_next;
        dur_sum_q  <= dur_next;
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      orig_q     <= origin_node_i;
      dest_q     <= dest_node_i;
      cur_q      <= dest_node_i;
      row_base_q <= cell_addr(origin_node_i, NodeW'(1));
    end
    if (walk_push) begin
      cur_q <= pred_rd;
    end
    if (load_leg) begin
      from_q <= stk_from;
      to_q   <= stk_to;
    end
    if (emit) begin
      case (state_q)
        S_LEG_EMIT: begin
          from_node_q <= from_q;
          to_node_q   <= to_q;
          step_dist_q <= OutW'(dist_rd);
          step_dur_q  <= OutW'(dur_rd);
          tot_dist_q  <= OutW'(dist_next);
          tot_dur_q   <= OutW'(dur_next);
          last_q      <= 1'b0;
        end
        S_FLAG: begin
          from_node_q <= dest_q;
          to_node_q   <= dest_q;
          step_dist_q <= '0;
          step_dur_q  <= '0;
          tot_dist_q  <= OutW'(dist_sum_q);
          tot_dur_q   <= OutW'(dur_sum_q);
          last_q      <= 1'b1;
        end
        S_COST_EMIT: begin
          from_node_q <= orig_q;
          to_node_q   <= dest_q;
          step_dist_q <= OutW'(dist_rd);
          step_dur_q  <= OutW'(dur_rd);
          tot_dist_q  <= OutW'(dist_rd);
          tot_dur_q   <= OutW'(dur_rd);
          last_q      <= 1'b1;
        end
        default: begin
          from_node_q <= orig_q;
          to_node_q   <= dest_q;
          step_dist_q <= '0;
          step_dur_q  <= '0;
          tot_dist_q  <= '0;
          tot_dur_q   <= '0;
          last_q      <= 1'b1;
        end
      endcase
    end
  end

  rfp_tables #(
    .Nodes     (Nodes),
    .CostWidth (CostWidth)
  ) u_tables (
    .clk_i        (clk_i),
    .cmd_i        (tbl_cmd),
    .addr_i       (tbl_addr),
    .pred_wdata_i (pred_wdata),
    .cost_wdata_i (cost_wdata),
    .pred_rdata_o (pred_rd),
    .dist_rdata_o (dist_rd),
    .dur_rdata_o  (dur_rd)
  );

  rfp_stack #(
    .Nodes (Nodes)
  ) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .re_i    (stk_re),
    .idx_i   (stk_idx),
    .wdata_i (stk_wdata),
    .rdata_o (stk_rd)
  );

  assign out_valid_o         = out_valid_q;
  assign from_node_o         = from_node_q;
  assign to_node_o           = to_node_q;
  assign step_distance_mm_o  = step_dist_q;
  assign step_duration_ms_o  = step_dur_q;
  assign total_distance_mm_o = tot_dist_q;
  assign total_duration_ms_o = tot_dur_q;
  assign last_o              = last_q;

  `RFP_ASSERT(a_legs_bound, clk_i, rst_ni, legs_q <= IdxW'(Nodes - 1), "leg stack overflow")
  `RFP_ASSERT_NEVER(a_no_write_busy, clk_i, rst_ni, (state_q != S_IDLE) && (tbl_cmd.pred_we || tbl_cmd.dist_we || tbl_cmd.dur_we), "table write during a query")
  `RFP_ASSERT(a_query_busy, clk_i, rst_ni, (in_accept && (mode_i == rfp_pkg::MODE_COST || mode_i == rfp_pkg::MODE_ROUTE)) |=> (state_q != S_IDLE), "query accepted without leaving idle")
  `RFP_ASSERT(a_mid_route, clk_i, rst_ni, (out_valid_o && !last_o) |-> (state_q == S_LEG_EMIT || state_q == S_FLAG), "non-final beat outside a route")
  `RFP_ASSERT(a_flag_last, clk_i, rst_ni, (state_q == S_FLAG && out_free) |=> (out_valid_o && last_o), "flag step not marked last")

endmodule
